// ===== sv/rssp_pkg.sv =====
`default_nettype none
package rssp_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int GEOM_W     = FRAC_BITS + 8;
   localparam int QUO_W      = GEOM_W;
   localparam int A_W        = 2 * GEOM_W;
   localparam int ROOT_W     = A_W / 2;
   localparam int UY_W       = FRAC_BITS + 1;
   localparam int DIM_W      = 13;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 2 * COORD_BITS;
   localparam int RSP_DATA_W = 2 * COORD_BITS + 24;

   localparam logic [DIM_W-1:0]  WIDTH_RST  = DIM_W'(200);
   localparam logic [DIM_W-1:0]  HEIGHT_RST = DIM_W'(100);
   localparam logic [15:0]       CZ_RST     = 16'd4096;
   localparam logic [14:0]       RADIUS_RST = 15'd2048;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_CX,
      CSR_CY,
      CSR_CZ,
      CSR_RADIUS
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
   } pos_type;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
      logic [14:0]        radius;
   } geo_cfg_type;

   typedef struct packed {
      pos_type pos;
      logic    ovf_x;
   } div_tag_type;

   typedef struct packed {
      pos_type             pos;
      logic                dy_neg;
      logic [GEOM_W-2:0]   dy_abs;
      logic                hit;
   } sky_tag_type;

   typedef struct packed {
      pos_type pos;
      logic    dy_neg;
      logic    hit;
   } uy_tag_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      pos_type    pos;
   } pixel_type;

endpackage
`default_nettype wire

// ===== sv/rssp_div.sv =====
`default_nettype none
module rssp_div #(
   parameter int DEN_W = 13,
   parameter int Q_W   = 24,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [DEN_W-1:0] in_rem,
   input  logic [Q_W-1:0]   in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quo,
   output logic [TAG_W-1:0] out_tag
);

   // One quotient bit per stage, restoring division.
   logic [Q_W-1:0]   vld_ff;
   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   num_ff [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];
   logic [TAG_W-1:0] tag_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic             v_src;
      logic [DEN_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [Q_W-1:0]   num_src;
      logic [Q_W-1:0]   quo_src;
      logic [TAG_W-1:0] tag_src;
      logic [DEN_W:0]   trial;
      logic             take;
      logic [DEN_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = in_rem;
         assign den_src = in_den;
         assign num_src = in_num;
         assign quo_src = '0;
         assign tag_src = in_tag;
      end else begin : g_next
         assign v_src   = vld_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign num_src = num_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign tag_src = tag_ff[k-1];
      end

      assign trial  = {rem_src, num_src[Q_W-1]};
      assign take   = trial >= {1'b0, den_src};
      assign rem_in = take ? DEN_W'(trial - {1'b0, den_src}) : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_src;
         end
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            num_ff[k] <= num_src << 1;
            quo_ff[k] <= {quo_src[Q_W-2:0], take};
            tag_ff[k] <= tag_src;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_quo   = quo_ff[Q_W-1];
   assign out_tag   = tag_ff[Q_W-1];

endmodule
`default_nettype wire

// ===== sv/rssp_isqrt.sv =====
`default_nettype none
module rssp_isqrt #(
   parameter int IN_W  = 48,
   parameter int TAG_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     in_rad,
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   out_root,
   output logic [TAG_W-1:0]    out_tag
);

   localparam int RT_W = IN_W / 2;
   localparam int R_W  = RT_W + 2;

   // One root bit per stage: two radicand bits come down each time.
   logic [RT_W-1:0]  vld_ff;
   logic [IN_W-1:0]  rad_ff  [RT_W];
   logic [R_W-1:0]   rem_ff  [RT_W];
   logic [RT_W-1:0]  root_ff [RT_W];
   logic [TAG_W-1:0] tag_ff  [RT_W];

   for (genvar k = 0; k < RT_W; k++) begin : g_stage
      logic             v_src;
      logic [IN_W-1:0]  rad_src;
      logic [R_W-1:0]   rem_src;
      logic [RT_W-1:0]  root_src;
      logic [TAG_W-1:0] tag_src;
      logic [R_W+1:0]   trial;
      logic [R_W+1:0]   cand;
      logic             take;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rad_src  = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign tag_src  = in_tag;
      end else begin : g_next
         assign v_src    = vld_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign tag_src  = tag_ff[k-1];
      end

      assign trial = {rem_src, rad_src[IN_W-1:IN_W-2]};
      assign cand  = (R_W+2)'({root_src, 2'b01});
      assign take  = trial >= cand;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_src;
         end
         if (en) begin
            rad_ff[k]  <= rad_src << 2;
            rem_ff[k]  <= take ? R_W'(trial - cand) : trial[R_W-1:0];
            root_ff[k] <= {root_src[RT_W-2:0], take};
            tag_ff[k]  <= tag_src;
         end
      end
   end

   assign out_valid = vld_ff[RT_W-1];
   assign out_root  = root_ff[RT_W-1];
   assign out_tag   = tag_ff[RT_W-1];

endmodule
`default_nettype wire

// ===== sv/rssp_hit.sv =====
`default_nettype none
module rssp_hit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rssp_pkg::QUO_W-1:0]    q_x,
   input  logic [rssp_pkg::QUO_W-1:0]    q_y,
   input  logic                          ovf_x,
   input  logic                          ovf_y,
   input  rssp_pkg::pos_type             in_pos,
   input  rssp_pkg::geo_cfg_type         cfg,
   output logic                          out_valid,
   output logic [rssp_pkg::A_W-1:0]      out_a,
   output logic                          out_hit,
   output rssp_pkg::pos_type             out_pos,
   output logic                          out_dy_neg,
   output logic [rssp_pkg::GEOM_W-2:0]   out_dy_abs
);
   import rssp_pkg::*;

   localparam int NSTG   = 7;
   localparam int PROD_W = 16 + GEOM_W;
   localparam int H_W    = PROD_W + 2;
   localparam int HH_W   = H_W / 2;
   localparam int C_W    = 34;
   localparam int CMP_W  = 2 * H_W;
   localparam logic signed [GEOM_W:0] GEOM_HI = (GEOM_W+1)'((1 << (GEOM_W - 1)) - 1);
   localparam logic signed [GEOM_W:0] TWO_ONE = (GEOM_W+1)'(1 << (FRAC_BITS + 1));
   localparam logic signed [GEOM_W:0] ONE     = (GEOM_W+1)'(1 << FRAC_BITS);

   logic [NSTG-1:0] vld_ff;
   pos_type         pos_ff [NSTG];

   // Direction, saturated to Q8.F.
   logic signed [GEOM_W:0]   vx, vy;
   logic signed [GEOM_W-1:0] dx_ff, dy_ff;

   // Products. The center is folded in as whole Q4.12, h and c scale by 2^4 and 2^8.
   logic signed [A_W-1:0]    px_ff, py_ff;
   logic signed [PROD_W-1:0] cxdx_ff, cydy_ff;
   logic signed [31:0]       sqx_ff, sqy_ff, sqz_ff;
   logic [29:0]              sqr_ff;
   logic                     dyn_ff [1:NSTG-1];
   logic [GEOM_W-2:0]        dya_ff [1:NSTG-1];
   logic [GEOM_W-1:0]        dyabs_in;

   logic [A_W-1:0]           a_ff [2:NSTG-2];
   logic signed [H_W-1:0]    h_ff;
   logic signed [C_W-1:0]    c_ff;

   logic [H_W-1:0]           habs_ff;
   logic                     cneg_ff [3:5];
   logic [31:0]              cu_ff;

   logic [H_W-1:0]           hh_ff, hl_ff, ll_ff;
   logic [A_W/2+31:0]        acl_ff, ach_ff;

   logic [CMP_W-1:0]         hsq_ff, ac_ff;
   logic                     hit_ff;

   assign vx = $signed({1'b0, q_x}) - TWO_ONE;
   assign vy = $signed({1'b0, q_y}) - ONE;
   assign dyabs_in = dy_ff[GEOM_W-1] ? GEOM_W'(-dy_ff) : dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0] <= in_pos;
         for (int k = 1; k < NSTG; k++) begin
            pos_ff[k] <= pos_ff[k-1];
         end
         dx_ff <= (ovf_x || vx > GEOM_HI) ? GEOM_HI[GEOM_W-1:0] : vx[GEOM_W-1:0];
         dy_ff <= (ovf_y || vy > GEOM_HI) ? GEOM_HI[GEOM_W-1:0] : vy[GEOM_W-1:0];

         px_ff   <= dx_ff * dx_ff;
         py_ff   <= dy_ff * dy_ff;
         cxdx_ff <= cfg.cx * dx_ff;
         cydy_ff <= cfg.cy * dy_ff;
         sqx_ff  <= cfg.cx * cfg.cx;
         sqy_ff  <= cfg.cy * cfg.cy;
         sqz_ff  <= cfg.cz * cfg.cz;
         sqr_ff  <= cfg.radius * cfg.radius;
         dyn_ff[1] <= dy_ff[GEOM_W-1];
         dya_ff[1] <= dyabs_in[GEOM_W-2:0];
         for (int k = 2; k < NSTG; k++) begin
            dyn_ff[k] <= dyn_ff[k-1];
            dya_ff[k] <= dya_ff[k-1];
         end

         a_ff[2] <= $unsigned(px_ff) + $unsigned(py_ff) + (A_W'(1) << (2 * FRAC_BITS));
         h_ff    <= ($signed(H_W'(cfg.cz)) <<< FRAC_BITS) - H_W'(cxdx_ff) - H_W'(cydy_ff);
         c_ff    <= C_W'(sqx_ff) + C_W'(sqy_ff) + C_W'(sqz_ff) - $signed({4'b0, sqr_ff});
         for (int k = 3; k < NSTG - 1; k++) begin
            a_ff[k] <= a_ff[k-1];
         end

         habs_ff    <= h_ff[H_W-1] ? H_W'(-h_ff) : h_ff;
         cneg_ff[3] <= c_ff[C_W-1];
         cu_ff      <= c_ff[31:0];
         cneg_ff[4] <= cneg_ff[3];
         cneg_ff[5] <= cneg_ff[4];

         hh_ff  <= H_W'(habs_ff[H_W-1:HH_W] * habs_ff[H_W-1:HH_W]);
         hl_ff  <= H_W'(habs_ff[H_W-1:HH_W] * habs_ff[HH_W-1:0]);
         ll_ff  <= H_W'(habs_ff[HH_W-1:0] * habs_ff[HH_W-1:0]);
         acl_ff <= a_ff[3][A_W/2-1:0] * cu_ff;
         ach_ff <= a_ff[3][A_W-1:A_W/2] * cu_ff;

         hsq_ff <= (CMP_W'(hh_ff) << (2 * HH_W)) + (CMP_W'(hl_ff) << (HH_W + 1))
                   + CMP_W'(ll_ff);
         ac_ff  <= (CMP_W'(ach_ff) << (A_W / 2)) + CMP_W'(acl_ff);

         hit_ff <= cneg_ff[5] || (hsq_ff > ac_ff);
      end
   end

   // The a value leaves after stage five and waits one stage with the compare.
   logic [A_W-1:0] a_out_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         a_out_ff <= a_ff[NSTG-2];
      end
   end

   assign out_valid  = vld_ff[NSTG-1];
   assign out_a      = a_out_ff;
   assign out_hit    = hit_ff;
   assign out_pos    = pos_ff[NSTG-1];
   assign out_dy_neg = dyn_ff[NSTG-1];
   assign out_dy_abs = dya_ff[NSTG-1];

endmodule
`default_nettype wire

// ===== sv/rssp_color.sv =====
`default_nettype none
module rssp_color (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [rssp_pkg::UY_W-1:0]  uy,
   input  logic                       in_dy_neg,
   input  logic                       in_hit,
   input  rssp_pkg::pos_type          in_pos,
   output logic                       out_valid,
   output rssp_pkg::pixel_type        out_pix
);
   import rssp_pkg::*;

   localparam int NSTG  = 4;
   localparam int U_W   = FRAC_BITS + 2;
   localparam int RF_W  = FRAC_BITS + 3;
   localparam int GF_W  = FRAC_BITS + 5;
   localparam int VR_W  = 15;
   localparam int VG_W  = 18;
   localparam logic [14:0]     KSCALE = 15'd25599;
   localparam logic [U_W-1:0]  ONE    = U_W'(1 << FRAC_BITS);
   localparam logic [RF_W-1:0] RBASE  = RF_W'(1 << (FRAC_BITS + 2));
   localparam logic [GF_W-1:0] GBASE  = GF_W'(10 * (1 << (FRAC_BITS + 1)));
   localparam logic [9:0]      RECIP_R = 10'd655;
   localparam logic [10:0]     RECIP_G = 11'd1048;

   logic [NSTG-1:0] vld_ff;
   pos_type         pos_ff [NSTG];
   logic            hit_ff [NSTG];

   logic [U_W-1:0]  u;
   logic [RF_W-1:0] rf_ff;
   logic [GF_W-1:0] gf_ff;
   logic [RF_W+14:0] prod_r;
   logic [GF_W+14:0] prod_g;
   logic [VR_W-1:0] vr_ff [2:3];
   logic [VG_W-1:0] vg_ff [2:3];
   logic [VR_W+9:0] prod_qr;
   logic [VG_W+10:0] prod_qg;
   logic [7:0]      qr_ff;
   logic [8:0]      qg_ff;
   logic [8:0]      red_q, green_q;
   logic [VR_W-1:0] rem_r;
   logic [VG_W-1:0] rem_g;
   pixel_type       pix_ff;

   assign u = in_dy_neg ? ONE - U_W'(uy) : ONE + U_W'(uy);

   assign prod_r  = (RF_W+15)'(rf_ff) * (RF_W+15)'(KSCALE);
   assign prod_g  = (GF_W+15)'(gf_ff) * (GF_W+15)'(KSCALE);
   assign prod_qr = (VR_W+10)'(vr_ff[2]) * (VR_W+10)'(RECIP_R);
   assign prod_qg = (VG_W+11)'(vg_ff[2]) * (VG_W+11)'(RECIP_G);

   // The reciprocal products run at most one low, one compare fixes that.
   assign rem_r   = vr_ff[3] - VR_W'(qr_ff * 7'd100);
   assign rem_g   = vg_ff[3] - VG_W'(qg_ff * 10'd1000);
   assign red_q   = 9'(qr_ff) + 9'(rem_r >= VR_W'(100));
   assign green_q = qg_ff + 9'(rem_g >= VG_W'(1000));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0] <= in_pos;
         hit_ff[0] <= in_hit;
         for (int k = 1; k < NSTG; k++) begin
            pos_ff[k] <= pos_ff[k-1];
            hit_ff[k] <= hit_ff[k-1];
         end
         rf_ff <= RBASE - RF_W'(u);
         gf_ff <= GBASE - GF_W'(u) - (GF_W'(u) << 1);

         vr_ff[2] <= prod_r[FRAC_BITS+2 +: VR_W];
         vg_ff[2] <= prod_g[FRAC_BITS+1 +: VG_W];

         vr_ff[3] <= vr_ff[2];
         vg_ff[3] <= vg_ff[2];
         qr_ff    <= prod_qr[16 +: 8];
         qg_ff    <= prod_qg[20 +: 9];

         pix_ff.pos <= pos_ff[NSTG-2];
         pix_ff.hit <= hit_ff[NSTG-2];
         if (hit_ff[NSTG-2]) begin
            pix_ff.red   <= 8'hFF;
            pix_ff.green <= 8'h00;
            pix_ff.blue  <= 8'h00;
         end else begin
            pix_ff.red   <= red_q[8] ? 8'hFF : red_q[7:0];
            pix_ff.green <= green_q[8] ? 8'hFF : green_q[7:0];
            pix_ff.blue  <= 8'hFF;
         end
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_pix   = pix_ff;

endmodule
`default_nettype wire

// ===== sv/ray_sphere_sky_pixel_shader.sv =====
// Channel   Direction  Signals                      Contents
// req       in         req_tvalid/tready/tdata      pixel column and row
// rsp       out        rsp_tvalid/tready/tdata/user pixel position, color, hit flag
// csr       in         csr_we/index/wdata           image size, sphere center, radius
//
// One pixel enters per cycle while rsp is not stalled, and its color leaves in order.
// The bit-serial pipelines hold 24 stages for the ray
// offset division, 24 for the square root and 17 for the y normalization.
// Reset is synchronous and empties every stage; configuration takes its reset values.
// A stall on rsp holds every stage together, so no transaction is lost or repeated.
`default_nettype none
module ray_sphere_sky_pixel_shader (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pixel_column, pixel_row
   input  logic [rssp_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_column, out_row, red, green, blue
   output logic [rssp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // sphere_hit
   output logic [0:0]                       rsp_tuser,
   input  logic                             csr_we,
   input  logic [rssp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rssp_pkg::CSR_W-1:0]       csr_wdata
);
   import rssp_pkg::*;

   localparam int XSH = QUO_W - FRAC_BITS - 2;
   localparam int YSH = QUO_W - FRAC_BITS - 1;

   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [15:0]       cx_ff, cy_ff, cz_ff;
   logic [14:0]       radius_ff;
   geo_cfg_type       cfg;

   logic              en;
   pos_type           req_pos;
   logic [DIM_W-1:0]  w_eff, h_eff;
   logic              ovf_x, ovf_y;
   div_tag_type       xtag_in, xtag_out;

   logic              x_valid, y_valid;
   logic [QUO_W-1:0]  q_x, q_y;
   logic [0:0]        ytag_out;

   logic              g_valid, g_hit, g_dy_neg;
   logic [A_W-1:0]    g_a;
   pos_type           g_pos;
   logic [GEOM_W-2:0] g_dy_abs;
   sky_tag_type       stag_in, stag_out;

   logic              s_valid;
   logic [ROOT_W-1:0] s_root;
   uy_tag_type        utag_in, utag_out;

   logic              u_valid;
   logic [UY_W-1:0]   u_quo;
   pixel_type         pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         cx_ff     <= '0;
         cy_ff     <= '0;
         cz_ff     <= CZ_RST;
         radius_ff <= RADIUS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_CX:     cx_ff     <= csr_wdata;
            CSR_CY:     cy_ff     <= csr_wdata;
            CSR_CZ:     cz_ff     <= csr_wdata;
            CSR_RADIUS: radius_ff <= csr_wdata[14:0];
            default:    ;
         endcase
      end
   end

   assign cfg.cx     = $signed(cx_ff);
   assign cfg.cy     = $signed(cy_ff);
   assign cfg.cz     = $signed(cz_ff);
   assign cfg.radius = radius_ff;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign req_pos.col = req_tdata[COORD_BITS-1:0];
   assign req_pos.row = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign w_eff = (width_ff == '0) ? DIM_W'(1) : width_ff;
   assign h_eff = (height_ff == '0) ? DIM_W'(1) : height_ff;

   // A quotient that does not fit the direction width saturates anyway.
   assign ovf_x = 32'(req_pos.col) >= (32'(w_eff) << XSH);
   assign ovf_y = 32'(req_pos.row) >= (32'(h_eff) << YSH);
   assign xtag_in.pos   = req_pos;
   assign xtag_in.ovf_x = ovf_x;

   rssp_div #(.DEN_W(DIM_W), .Q_W(QUO_W), .TAG_W($bits(div_tag_type))) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_rem    (DIM_W'(req_pos.col >> XSH)),
      .in_num    (QUO_W'(req_pos.col) << (QUO_W - XSH)),
      .in_den    (w_eff),
      .in_tag    (xtag_in),
      .out_valid (x_valid),
      .out_quo   (q_x),
      .out_tag   (xtag_out)
   );

   rssp_div #(.DEN_W(DIM_W), .Q_W(QUO_W), .TAG_W(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_rem    (DIM_W'(req_pos.row >> YSH)),
      .in_num    (QUO_W'(req_pos.row) << (QUO_W - YSH)),
      .in_den    (h_eff),
      .in_tag    (ovf_y),
      .out_valid (y_valid),
      .out_quo   (q_y),
      .out_tag   (ytag_out)
   );

   rssp_hit u_hit (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (x_valid),
      .q_x        (q_x),
      .q_y        (q_y),
      .ovf_x      (xtag_out.ovf_x),
      .ovf_y      (ytag_out[0]),
      .in_pos     (xtag_out.pos),
      .cfg        (cfg),
      .out_valid  (g_valid),
      .out_a      (g_a),
      .out_hit    (g_hit),
      .out_pos    (g_pos),
      .out_dy_neg (g_dy_neg),
      .out_dy_abs (g_dy_abs)
   );

   assign stag_in.pos    = g_pos;
   assign stag_in.dy_neg = g_dy_neg;
   assign stag_in.dy_abs = g_dy_abs;
   assign stag_in.hit    = g_hit;

   rssp_isqrt #(.IN_W(A_W), .TAG_W($bits(sky_tag_type))) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid),
      .in_rad    (g_a),
      .in_tag    (stag_in),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_tag   (stag_out)
   );

   assign utag_in.pos    = stag_out.pos;
   assign utag_in.dy_neg = stag_out.dy_neg;
   assign utag_in.hit    = stag_out.hit;

   // The root is at least one, so the division by it is always defined.
   rssp_div #(.DEN_W(ROOT_W), .Q_W(UY_W), .TAG_W($bits(uy_tag_type))) u_div_uy (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_rem    (ROOT_W'(stag_out.dy_abs >> 1)),
      .in_num    (UY_W'(stag_out.dy_abs) << FRAC_BITS),
      .in_den    (s_root),
      .in_tag    (utag_in),
      .out_valid (u_valid),
      .out_quo   (u_quo),
      .out_tag   (utag_out)
   );

   rssp_color u_color (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (u_valid),
      .uy        (u_quo),
      .in_dy_neg (utag_out.dy_neg),
      .in_hit    (utag_out.hit),
      .in_pos    (utag_out.pos),
      .out_valid (rsp_tvalid),
      .out_pix   (pix)
   );

   assign rsp_tdata    = {pix.blue, pix.green, pix.red, pix.pos.row, pix.pos.col};
   assign rsp_tuser[0] = pix.hit;

`ifndef NO_ASSERTIONS
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      x_valid == y_valid)
      else $error("ray offset dividers out of step");

   a_hit_red: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[47:24] == 24'h0000FF)
      else $error("hit pixel is not pure red");

   a_sky_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[47:40] == 8'hFF)
      else $error("sky pixel blue channel not full");
`endif

endmodule
`default_nettype wire
